// ----- hw/rtl/bph_pkg.sv -----
// shared types, constants and helpers of the byte pair histogram
package bph_pkg;

   localparam int COUNT_BITS = 16;
   localparam int CELL_BITS  = 16;
   localparam int OUT_BITS   = 16;
   localparam int PROD_BITS  = COUNT_BITS + 16;
   localparam int REM_BITS   = COUNT_BITS + 8;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
   localparam logic [CELL_BITS-1:0]  CELL_LAST = {CELL_BITS{1'b1}};

   localparam int CSR_INDEX_BITS = 4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ALPHA_STEP = 4'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_USE_PEAK   = 4'd1;

   localparam logic FUNC_PUSH = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   localparam logic [7:0] ALPHA_MAX  = 8'd255;
   localparam logic [7:0] PEAK_SCALE = 8'd255;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_ALPHA,
      ST_DELIVER
   } top_state_type;

   typedef enum logic [1:0] {
      AL_IDLE,
      AL_CHECK,
      AL_DIVIDE
   } alpha_state_type;

   typedef struct packed {
      logic                  start;
      logic [COUNT_BITS-1:0] count;
      logic [COUNT_BITS-1:0] peak;
      logic [7:0]            step;
      logic                  use_peak;
   } alpha_req_type;

   typedef struct packed {
      logic       done;
      logic [7:0] alpha;
   } alpha_rsp_type;

   // clamp a count to the 16-bit result fields
   function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] value);
      logic [OUT_BITS-1:0] result;
      if (COUNT_BITS > OUT_BITS && value > COUNT_BITS'({OUT_BITS{1'b1}})) begin
         result = {OUT_BITS{1'b1}};
      end else begin
         result = OUT_BITS'(value);
      end
      return result;
   endfunction

endpackage

// ----- hw/rtl/bph_ifaces.sv -----
// request, response and register write channels of the byte pair histogram

interface bph_req_if;
   logic       valid;
   logic       ready;
   logic       func;
   logic [7:0] data_byte;
   logic [7:0] cell_x;
   logic [7:0] cell_y;

   modport source (output valid, func, data_byte, cell_x, cell_y, input ready);
   modport sink   (input valid, func, data_byte, cell_x, cell_y, output ready);
endinterface

interface bph_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] cell_count;
   logic [7:0]  alpha;
   logic [15:0] peak_count;

   modport source (output valid, cell_count, alpha, peak_count, input ready);
   modport sink   (input valid, cell_count, alpha, peak_count, output ready);
endinterface

interface bph_csr_if;
   logic       valid;
   logic       ready;
   logic [3:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/bph_alpha.sv -----
// alpha unit: count times gain, then saturate or divide by peak one quotient bit a cycle
module bph_alpha
   import bph_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  alpha_req_type alpha_req,
   output alpha_rsp_type alpha_rsp
);

   alpha_state_type       state_ff, state_in;
   logic [PROD_BITS-1:0]  prod_ff, prod_in;
   logic [COUNT_BITS-1:0] peak_ff, peak_in;
   logic                  use_peak_ff, use_peak_in;
   logic [REM_BITS-1:0]   rem_ff, rem_in;
   logic [REM_BITS-1:0]   div_ff, div_in;
   logic [7:0]            quot_ff, quot_in;
   logic [2:0]            bit_ff, bit_in;
   logic                  done_ff, done_in;
   logic [7:0]            alpha_ff, alpha_in;
   logic [15:0]           scale;
   logic                  fits;

   // gain becomes 255*step in peak mode, so one multiply serves both modes
   assign scale = alpha_req.use_peak ? (16'(alpha_req.step) * 16'(PEAK_SCALE))
                                     : 16'(alpha_req.step);
   // quotient below 256 exactly when product is below peak*256
   assign fits  = prod_ff < (PROD_BITS'(peak_ff) << 8);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         AL_IDLE: begin
            if (alpha_req.start) begin
               state_in = AL_CHECK;
            end
         end
         AL_CHECK: begin
            if (use_peak_ff && peak_ff != '0 && fits) begin
               state_in = AL_DIVIDE;
            end else begin
               state_in = AL_IDLE;
            end
         end
         AL_DIVIDE: begin
            if (bit_ff == '0) begin
               state_in = AL_IDLE;
            end
         end
         default: state_in = AL_IDLE;
      endcase
   end

   always_comb begin
      prod_in     = prod_ff;
      peak_in     = peak_ff;
      use_peak_in = use_peak_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      quot_in     = quot_ff;
      bit_in      = bit_ff;
      done_in     = 1'b0;
      alpha_in    = alpha_ff;
      unique case (state_ff)
         AL_IDLE: begin
            if (alpha_req.start) begin
               prod_in     = PROD_BITS'(alpha_req.count) * PROD_BITS'(scale);
               peak_in     = alpha_req.peak;
               use_peak_in = alpha_req.use_peak;
            end
         end
         AL_CHECK: begin
            rem_in  = REM_BITS'(prod_ff);
            div_in  = REM_BITS'(peak_ff) << 7;
            quot_in = '0;
            bit_in  = 3'd7;
            if (!use_peak_ff) begin
               done_in  = 1'b1;
               alpha_in = (prod_ff > PROD_BITS'(ALPHA_MAX)) ? ALPHA_MAX : prod_ff[7:0];
            end else if (peak_ff == '0) begin
               done_in  = 1'b1;
               alpha_in = '0;
            end else if (!fits) begin
               done_in  = 1'b1;
               alpha_in = ALPHA_MAX;
            end
         end
         AL_DIVIDE: begin
            if (rem_ff >= div_ff) begin
               rem_in  = rem_ff - div_ff;
               quot_in = {quot_ff[6:0], 1'b1};
            end else begin
               quot_in = {quot_ff[6:0], 1'b0};
            end
            div_in = div_ff >> 1;
            bit_in = bit_ff - 3'd1;
            if (bit_ff == '0) begin
               done_in  = 1'b1;
               alpha_in = quot_in;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= AL_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      prod_ff     <= prod_in;
      peak_ff     <= peak_in;
      use_peak_ff <= use_peak_in;
      rem_ff      <= rem_in;
      div_ff      <= div_in;
      quot_ff     <= quot_in;
      bit_ff      <= bit_in;
      alpha_ff    <= alpha_in;
   end

   assign alpha_rsp.done  = done_ff;
   assign alpha_rsp.alpha = alpha_ff;

endmodule

// ----- hw/rtl/byte_pair_histogram_top.sv -----
// byte pair histogram: pair count memory, sequencer and response register
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    func, data_byte, cell_x, cell_y
//   rsp_bus   out   valid/ready    cell_count, alpha, peak_count
//   csr_bus   in    valid/ready    index, data (always ready)
//
// one request at a time: a request is accepted in idle, then passes lookup, alpha and deliver;
// in peak mode, when the quotient fits, the 8-step divider in the alpha unit runs during alpha
// after reset a clearing pass writes zero to all 65536 cells, req not ready
// a finished response waits in the output register while the next request is taken
module byte_pair_histogram_top
   import bph_pkg::*;
(
   input logic       clock,
   input logic       reset,
   bph_req_if.sink   req_bus,
   bph_rsp_if.source rsp_bus,
   bph_csr_if.sink   csr_bus
);

   logic [COUNT_BITS-1:0] mem [2**CELL_BITS];

   top_state_type         state_ff, state_in;
   logic [CELL_BITS-1:0]  clear_addr_ff, clear_addr_in;
   logic [7:0]            prev_byte_ff, prev_byte_in;
   logic                  have_prev_ff, have_prev_in;
   logic [COUNT_BITS-1:0] peak_ff, peak_in;
   logic [7:0]            alpha_step_ff, alpha_step_in;
   logic                  use_peak_ff, use_peak_in;

   logic                  func_ff, func_in;
   logic                  first_ff, first_in;
   logic [CELL_BITS-1:0]  addr_ff, addr_in;
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [7:0]            alpha_ff, alpha_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]   rsp_count_ff, rsp_count_in;
   logic [7:0]            rsp_alpha_ff, rsp_alpha_in;
   logic [OUT_BITS-1:0]   rsp_peak_ff, rsp_peak_in;

   logic                  req_take;
   logic                  rd_en;
   logic                  wr_en;
   logic [CELL_BITS-1:0]  wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic [CELL_BITS-1:0]  req_addr;
   logic [COUNT_BITS-1:0] lookup_count;
   logic                  bump;
   logic                  slot_free;
   logic                  rsp_load;
   alpha_req_type         alpha_req;
   alpha_rsp_type         alpha_rsp;

   assign req_take  = req_bus.valid && req_bus.ready;
   assign slot_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_addr  = (req_bus.func == FUNC_PUSH) ? {req_bus.data_byte, prev_byte_ff}
                                                  : {req_bus.cell_y, req_bus.cell_x};
   assign bump      = (func_ff == FUNC_PUSH) && !first_ff;

   // the next request waits for this write, so the read never sees a stale cell
   always_comb begin
      if (first_ff) begin
         lookup_count = '0;
      end else if (func_ff == FUNC_READ || rd_data_ff == COUNT_MAX) begin
         lookup_count = rd_data_ff;
      end else begin
         lookup_count = rd_data_ff + 1'b1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clear_addr_ff == CELL_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP:  state_in = ST_ALPHA;
         ST_ALPHA: begin
            if (alpha_rsp.done) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      req_bus.ready = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = addr_ff;
      wr_data       = lookup_count;
      rsp_load      = 1'b0;
      clear_addr_in = clear_addr_ff;
      prev_byte_in  = prev_byte_ff;
      have_prev_in  = have_prev_ff;
      peak_in       = peak_ff;
      func_in       = func_ff;
      first_in      = first_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      alpha_in      = alpha_ff;
      alpha_req     = '{start: 1'b0, count: lookup_count, peak: peak_ff,
                        step: alpha_step_ff, use_peak: use_peak_ff};
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en         = 1'b1;
            wr_addr       = clear_addr_ff;
            wr_data       = '0;
            clear_addr_in = clear_addr_ff + 1'b1;
         end
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_take) begin
               func_in  = req_bus.func;
               addr_in  = req_addr;
               first_in = (req_bus.func == FUNC_PUSH) && !have_prev_ff;
               rd_en    = 1'b1;
               if (req_bus.func == FUNC_PUSH) begin
                  prev_byte_in = req_bus.data_byte;
                  have_prev_in = 1'b1;
               end
            end
         end
         ST_LOOKUP: begin
            wr_en    = bump;
            count_in = lookup_count;
            if (bump && lookup_count > peak_ff) begin
               peak_in        = lookup_count;
               alpha_req.peak = lookup_count;
            end
            alpha_req.start = 1'b1;
         end
         ST_ALPHA: begin
            if (alpha_rsp.done) begin
               alpha_in = alpha_rsp.alpha;
            end
         end
         ST_DELIVER: begin
            rsp_load = slot_free;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      alpha_step_in = alpha_step_ff;
      use_peak_in   = use_peak_ff;
      csr_bus.ready = 1'b1;
      if (csr_bus.valid) begin
         if (csr_bus.index == CSR_ALPHA_STEP) begin
            alpha_step_in = csr_bus.data;
         end else if (csr_bus.index == CSR_USE_PEAK) begin
            use_peak_in = csr_bus.data[0];
         end
      end
   end

   always_comb begin
      rsp_count_in = rsp_count_ff;
      rsp_alpha_in = rsp_alpha_ff;
      rsp_peak_in  = rsp_peak_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_count_in = sat_out(count_ff);
         rsp_alpha_in = alpha_ff;
         rsp_peak_in  = sat_out(peak_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[req_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clear_addr_ff <= '0;
         prev_byte_ff  <= '0;
         have_prev_ff  <= 1'b0;
         peak_ff       <= '0;
         alpha_step_ff <= 8'd1;
         use_peak_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         prev_byte_ff  <= prev_byte_in;
         have_prev_ff  <= have_prev_in;
         peak_ff       <= peak_in;
         alpha_step_ff <= alpha_step_in;
         use_peak_ff   <= use_peak_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      func_ff      <= func_in;
      first_ff     <= first_in;
      addr_ff      <= addr_in;
      count_ff     <= count_in;
      alpha_ff     <= alpha_in;
      rsp_count_ff <= rsp_count_in;
      rsp_alpha_ff <= rsp_alpha_in;
      rsp_peak_ff  <= rsp_peak_in;
   end

   bph_alpha u_alpha (
      .clock     (clock),
      .reset     (reset),
      .alpha_req (alpha_req),
      .alpha_rsp (alpha_rsp)
   );

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.cell_count = rsp_count_ff;
   assign rsp_bus.alpha      = rsp_alpha_ff;
   assign rsp_bus.peak_count = rsp_peak_ff;

endmodule

// ----- verif/tb_top.sv -----
// self-checking testbench of the byte pair histogram: pushes, cell reads and alpha gain modes
module tb_top
   import bph_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_SPARE = 4'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INDEX_TOP   = 4'd15;
   localparam int DRAIN_CYCLES  = 20;
   localparam int HOLD_CYCLES   = 300;
   localparam int MAX_PRINTED   = 100;
   localparam int REPEAT_PUSHES = 40;

   typedef struct packed {
      logic [15:0] cell_count;
      logic [7:0]  alpha;
      logic [15:0] peak_count;
   } cell_result_type;

   logic clock = 1'b0;
   logic reset;

   bph_req_if req_bus ();
   bph_rsp_if rsp_bus ();
   bph_csr_if csr_bus ();

   byte_pair_histogram_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   always #4 clock = ~clock;

   // mirror of the histogram state and the registers
   logic [COUNT_BITS-1:0] pair_hist [0:65535];
   logic [7:0]            last_byte       = 8'd0;
   logic                  last_byte_valid = 1'b0;
   logic [COUNT_BITS-1:0] peak_seen       = '0;
   logic [7:0]            alpha_gain      = 8'd1;
   logic                  peak_scaled     = 1'b0;

   cell_result_type cell_results_due [$];

   bit          req_idle_on     = 1'b0;
   bit          rsp_idle_on     = 1'b0;
   int unsigned rsp_wait        = 0;
   int unsigned rsp_hold_cycles = 0;

   int unsigned error_count      = 0;
   int unsigned push_count       = 0;
   int unsigned read_count       = 0;
   int unsigned csr_write_count  = 0;
   int unsigned results_checked  = 0;
   int unsigned req_stall_cycles = 0;

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= MAX_PRINTED) begin
         $display("tb_top: %s", msg);
      end
   endtask

   function automatic logic [15:0] clamp_out(input logic [COUNT_BITS-1:0] value);
      return (value > COUNT_BITS'(16'hFFFF)) ? 16'hFFFF : 16'(value);
   endfunction

   function automatic logic [7:0] alpha_for(input logic [COUNT_BITS-1:0] count);
      longint unsigned scaled;
      if (peak_scaled) begin
         if (peak_seen == '0) begin
            return 8'd0;
         end
         scaled = (64'(count) * 64'(PEAK_SCALE) * 64'(alpha_gain)) / 64'(peak_seen);
      end else begin
         scaled = 64'(count) * 64'(alpha_gain);
      end
      return (scaled > 64'(ALPHA_MAX)) ? ALPHA_MAX : scaled[7:0];
   endfunction

   // applies one request to the mirror and returns the result it must produce
   function automatic cell_result_type histogram_update(input logic func,
                                                        input logic [7:0] data,
                                                        input logic [7:0] x,
                                                        input logic [7:0] y);
      cell_result_type       res;
      logic [15:0]           cell_idx;
      logic [COUNT_BITS-1:0] count;
      if (func == FUNC_PUSH && !last_byte_valid) begin
         last_byte       = data;
         last_byte_valid = 1'b1;
         res.cell_count  = 16'd0;
         res.alpha       = 8'd0;
         res.peak_count  = clamp_out(peak_seen);
         return res;
      end
      if (func == FUNC_PUSH) begin
         cell_idx = {data, last_byte};
         count    = pair_hist[cell_idx];
         if (count != COUNT_MAX) begin
            count = count + 1'b1;
         end
         pair_hist[cell_idx] = count;
         if (count > peak_seen) begin
            peak_seen = count;
         end
         last_byte = data;
      end else begin
         cell_idx = {y, x};
         count    = pair_hist[cell_idx];
      end
      res.cell_count = clamp_out(count);
      res.alpha      = alpha_for(count);
      res.peak_count = clamp_out(peak_seen);
      return res;
   endfunction

   task automatic send_request(input logic func, input logic [7:0] data,
                               input logic [7:0] x, input logic [7:0] y);
      int unsigned gap;
      gap = req_idle_on ? $urandom_range(0, 7) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.func      <= func;
      req_bus.data_byte <= data;
      req_bus.cell_x    <= x;
      req_bus.cell_y    <= y;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      cell_results_due.push_back(histogram_update(func, data, x, y));
      if (func == FUNC_PUSH) begin
         push_count++;
      end else begin
         read_count++;
      end
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (cell_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index, input logic [7:0] value);
      wait_drained();
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= index;
      csr_bus.data  <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      case (index)
         CSR_ALPHA_STEP: alpha_gain = value;
         CSR_USE_PEAK:   peak_scaled = value[0];
         default: ;
      endcase
      csr_write_count++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // response side: per-result stall, plus a long hold when a test asks for one
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_bus.ready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cell_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_checked++;
         rsp_wait = rsp_idle_on ? $urandom_range(0, 7) : 0;
         if (cell_results_due.size() == 0) begin
            report_error($sformatf("result %0d arrived with no request pending",
                                   results_checked));
         end else begin
            want = cell_results_due.pop_front();
            if (rsp_bus.cell_count !== want.cell_count) begin
               report_error($sformatf("result %0d cell_count %0d, expected %0d",
                                      results_checked, rsp_bus.cell_count, want.cell_count));
            end
            if (rsp_bus.alpha !== want.alpha) begin
               report_error($sformatf("result %0d alpha %0d, expected %0d",
                                      results_checked, rsp_bus.alpha, want.alpha));
            end
            if (rsp_bus.peak_count !== want.peak_count) begin
               report_error($sformatf("result %0d peak_count %0d, expected %0d",
                                      results_checked, rsp_bus.peak_count, want.peak_count));
            end
         end
      end
      if (!reset && req_bus.valid && !req_bus.ready) begin
         req_stall_cycles++;
      end
   end

   // peak mode before any pair exists, then the first byte of the stream
   task automatic test_first_byte_and_zero_peak();
      write_register(CSR_USE_PEAK, 8'h01);
      write_register(CSR_ALPHA_STEP, 8'd200);
      send_request(FUNC_READ, 8'h00, 8'hFF, 8'hFF);
      send_request(FUNC_PUSH, 8'hFF, 8'h00, 8'h00);
      send_request(FUNC_READ, 8'hFF, 8'h00, 8'h00);
      send_request(FUNC_PUSH, 8'h00, 8'hFF, 8'hFF);
      send_request(FUNC_READ, 8'h00, 8'hFF, 8'h00);
      write_register(CSR_ALPHA_STEP, 8'd1);
      send_request(FUNC_READ, 8'h00, 8'hFF, 8'h00);
      send_request(FUNC_PUSH, 8'h00, 8'h00, 8'h00);
      send_request(FUNC_PUSH, 8'h00, 8'h00, 8'h00);
      send_request(FUNC_READ, 8'h00, 8'hFF, 8'h00);
   endtask

   // x is the column and y the row: mirrored cells must stay apart
   task automatic test_cell_order_and_gain();
      write_register(CSR_USE_PEAK, 8'hFE);
      send_request(FUNC_PUSH, 8'hFF, 8'h00, 8'h00);
      send_request(FUNC_PUSH, 8'hFF, 8'h00, 8'h00);
      send_request(FUNC_READ, 8'h00, 8'h00, 8'hFF);
      send_request(FUNC_READ, 8'hFF, 8'hFF, 8'h00);
      send_request(FUNC_READ, 8'h00, 8'hFF, 8'hFF);
      send_request(FUNC_PUSH, 8'hA5, 8'h5A, 8'hA5);
      send_request(FUNC_PUSH, 8'h5A, 8'hA5, 8'h5A);
      send_request(FUNC_READ, 8'h00, 8'hA5, 8'h5A);
      write_register(CSR_ALPHA_STEP, 8'd255);
      send_request(FUNC_READ, 8'hFF, 8'h00, 8'h00);
      write_register(CSR_ALPHA_STEP, 8'd0);
      send_request(FUNC_READ, 8'hFF, 8'h00, 8'h00);
   endtask

   // writes to indexes outside the register list change nothing
   task automatic test_spare_register_index();
      write_register(CSR_INDEX_SPARE, 8'hFF);
      write_register(CSR_INDEX_TOP, 8'h05);
      send_request(FUNC_READ, 8'h00, 8'h00, 8'h00);
      write_register(CSR_ALPHA_STEP, 8'd3);
      send_request(FUNC_READ, 8'h00, 8'h00, 8'h00);
   endtask

   task automatic run_traffic_phase(input int unsigned count, input logic [7:0] gain,
                                    input logic peak_mode, input bit req_idle,
                                    input bit rsp_idle);
      logic [7:0] pool [4];
      logic       func;
      logic [7:0] data;
      logic [7:0] x;
      logic [7:0] y;
      write_register(CSR_ALPHA_STEP, gain);
      write_register(CSR_USE_PEAK, {7'($urandom), peak_mode});
      req_idle_on = req_idle;
      rsp_idle_on = rsp_idle;
      foreach (pool[i]) pool[i] = 8'($urandom);
      repeat (count) begin
         func = ($urandom_range(0, 9) < 3) ? FUNC_READ : FUNC_PUSH;
         data = $urandom_range(0, 1) ? pool[$urandom_range(0, 3)] : 8'($urandom);
         x    = 8'($urandom);
         y    = 8'($urandom);
         // most reads aim at cells the stream is likely to have filled
         if (func == FUNC_READ && $urandom_range(0, 2) != 0) begin
            x = last_byte;
            y = pool[$urandom_range(0, 3)];
         end
         send_request(func, data, x, y);
      end
   endtask

   task automatic test_random_traffic();
      run_traffic_phase(270, 8'd1, 1'b0, 1'b1, 1'b1);
      run_traffic_phase(270, 8'd0, 1'b0, 1'b0, 1'b0);
      run_traffic_phase(270, 8'd255, 1'b0, 1'b1, 1'b0);
      run_traffic_phase(270, 8'($urandom_range(2, 254)), 1'b1, 1'b1, 1'b1);
      run_traffic_phase(270, 8'd255, 1'b1, 1'b0, 1'b1);
      run_traffic_phase(270, 8'd1, 1'b1, 1'b1, 1'b1);
      run_traffic_phase(270, 8'($urandom), 1'b0, 1'b1, 1'b1);
   endtask

   // responses held back long enough that the block has to stop taking requests
   task automatic test_response_hold();
      wait_drained();
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      @(posedge clock);
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (16) begin
         send_request($urandom_range(0, 1) ? FUNC_READ : FUNC_PUSH, 8'($urandom),
                      last_byte, 8'($urandom));
      end
   endtask

   // one pair pushed over and over so it leads the peak, then read in both modes
   task automatic test_repeated_pair();
      write_register(CSR_USE_PEAK, 8'h00);
      write_register(CSR_ALPHA_STEP, 8'd255);
      req_idle_on = 1'b0;
      rsp_idle_on = 1'b0;
      repeat (REPEAT_PUSHES) begin
         send_request(FUNC_PUSH, 8'h00, 8'($urandom), 8'($urandom));
      end
      send_request(FUNC_READ, 8'($urandom), 8'h00, 8'h00);
      write_register(CSR_USE_PEAK, 8'h01);
      write_register(CSR_ALPHA_STEP, 8'd1);
      send_request(FUNC_READ, 8'($urandom), 8'h00, 8'h00);
      req_idle_on = 1'b1;
      rsp_idle_on = 1'b1;
      repeat (6) begin
         send_request($urandom_range(0, 1) ? FUNC_READ : FUNC_PUSH, 8'($urandom),
                      8'($urandom), 8'($urandom));
      end
   endtask

   initial begin
      foreach (pair_hist[i]) pair_hist[i] = '0;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.func      = FUNC_PUSH;
      req_bus.data_byte = 8'd0;
      req_bus.cell_x    = 8'd0;
      req_bus.cell_y    = 8'd0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_ALPHA_STEP;
      csr_bus.data      = 8'd0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_first_byte_and_zero_peak();
      test_cell_order_and_gain();
      test_spare_register_index();
      test_random_traffic();
      test_response_hold();
      test_repeated_pair();
      wait_drained();

      $display("tb_top: %0d pushes and %0d cell reads over %0d register writes, %0d results",
               push_count, read_count, csr_write_count, results_checked);
      $display("tb_top: highest pair count %0d, %0d cycles with requests stalled",
               peak_seen, req_stall_cycles);
      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   // covers the clearing pass and the idled traffic several times over
   initial begin
      #20_000_000;
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
